// ===== design/vfcm_pkg.sv =====
// ---------------------------------------------------------------------------
// vfcm_pkg
// Shared widths, defaults and codes for the voxel face culling mesher.
// ---------------------------------------------------------------------------
package vfcm_pkg;

    localparam int SIZE_X_DEF    = 64;
    localparam int SIZE_Y_DEF    = 64;
    localparam int SIZE_Z_DEF    = 64;
    localparam int TYPE_BITS_DEF = 4;

    localparam int COORD_W    = 6;
    localparam int ID_W       = 4;
    localparam int DIR_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int NUM_DIRS   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIQUID_ID = 2'd1;

    localparam logic [CFG_DATA_W-1:0] EMPTY_ID_RST  = 4'd0;
    localparam logic [CFG_DATA_W-1:0] LIQUID_ID_RST = 4'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    localparam logic [DIR_W-1:0] DIR_UP   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN = 3'd1;
    localparam logic [DIR_W-1:0] DIR_XP   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_XN   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_ZP   = 3'd4;
    localparam logic [DIR_W-1:0] DIR_ZN   = 3'd5;

endpackage

// ===== design/vfcm_ram.sv =====
// ---------------------------------------------------------------------------
// vfcm_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module vfcm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/voxel_face_culling_mesher.sv =====
// ---------------------------------------------------------------------------
// voxel_face_culling_mesher
// Voxel grid store with exposed face extraction for one cell per command.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A write command
// keeps busy high through the row, address and write states, a mesh command
// through the row, address, self read and self check states and, if the cell
// holds the wanted type, one neighbor state per direction and one emit state
// per exposed face: the cell and its six neighbors are read one after another
// through the single read port of the grid memory, then the face records
// leave on consecutive cycles, one per o_face_valid pulse, with o_last on the
// final one. The receiver cannot stall the face stream. Out-of-grid commands
// are dropped without going busy. The grid is not cleared after reset.
module voxel_face_culling_mesher #(
    parameter int SIZE_X    = vfcm_pkg::SIZE_X_DEF,
    parameter int SIZE_Y    = vfcm_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z    = vfcm_pkg::SIZE_Z_DEF,
    parameter int TYPE_BITS = vfcm_pkg::TYPE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [vfcm_pkg::COORD_W-1:0]    i_pos_x,
    input  logic [vfcm_pkg::COORD_W-1:0]    i_pos_y,
    input  logic [vfcm_pkg::COORD_W-1:0]    i_pos_z,
    input  logic [vfcm_pkg::ID_W-1:0]       i_block_id,
    input  logic [vfcm_pkg::ID_W-1:0]       i_wanted_type,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vfcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_face_valid,
    output logic [vfcm_pkg::COORD_W-1:0]    o_face_x,
    output logic [vfcm_pkg::COORD_W-1:0]    o_face_y,
    output logic [vfcm_pkg::COORD_W-1:0]    o_face_z,
    output logic [vfcm_pkg::DIR_W-1:0]      o_face_dir,
    output logic                            o_liquid_top,
    output logic                            o_last
);

    import vfcm_pkg::*;

    localparam int CELLS = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] OFS_X = AW'(1);
    localparam logic [AW-1:0] OFS_Y = AW'(SIZE_X);
    localparam logic [AW-1:0] OFS_Z = AW'(SIZE_X * SIZE_Y);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ROW      = 3'd1;
    localparam logic [2:0] S_ADDR     = 3'd2;
    localparam logic [2:0] S_WRITE    = 3'd3;
    localparam logic [2:0] S_SELF_RD  = 3'd4;
    localparam logic [2:0] S_SELF_CHK = 3'd5;
    localparam logic [2:0] S_NEIGH    = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    typedef logic [TYPE_BITS-1:0] t_id;

    logic [2:0]            r_state, n_state;
    logic                  r_op, n_op;
    logic [COORD_W-1:0]    r_x, n_x;
    logic [COORD_W-1:0]    r_y, n_y;
    logic [COORD_W-1:0]    r_z, n_z;
    t_id                   r_blk, n_blk;
    t_id                   r_want, n_want;
    logic [AW-1:0]         r_addr, n_addr;
    logic [DIR_W-1:0]      r_dir, n_dir;
    logic                  r_liquid, n_liquid;
    logic [NUM_DIRS-1:0]   r_face, n_face;
    logic [CFG_DATA_W-1:0] r_empty_cfg, r_liquid_cfg;
    logic                  r_out_valid, n_out_valid;
    logic [DIR_W-1:0]      r_out_dir, n_out_dir;
    logic                  r_out_last, n_out_last;

    t_id                   empty_t, liquid_t, rd_id;
    logic                  in_range, bnd, face_bit;
    logic [DIR_W-1:0]      nb_dir;
    logic [AW-1:0]         nb_addr, ram_raddr;
    logic                  ram_we;
    logic [DIR_W-1:0]      pick_dir;
    logic [NUM_DIRS-1:0]   pick_hot, rest;
    logic                  found;

    assign empty_t  = TYPE_BITS'(r_empty_cfg);
    assign liquid_t = TYPE_BITS'(r_liquid_cfg);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign in_range = (32'(i_pos_x) < SIZE_X) && (32'(i_pos_y) < SIZE_Y)
                      && (32'(i_pos_z) < SIZE_Z);

    // shared address adder: cell address plus or minus a neighbour step
    always_comb begin
        unique case (nb_dir)
            DIR_UP:   nb_addr = r_addr + OFS_Y;
            DIR_DOWN: nb_addr = r_addr - OFS_Y;
            DIR_XP:   nb_addr = r_addr + OFS_X;
            DIR_XN:   nb_addr = r_addr - OFS_X;
            DIR_ZP:   nb_addr = r_addr + OFS_Z;
            DIR_ZN:   nb_addr = r_addr - OFS_Z;
            default:  nb_addr = r_addr;
        endcase
    end

    assign nb_dir    = (r_state == S_SELF_CHK) ? DIR_UP : r_dir + DIR_W'(1);
    assign ram_raddr = (r_state == S_SELF_RD) ? r_addr : nb_addr;
    assign ram_we    = (r_state == S_WRITE);

    vfcm_ram #(
        .WIDTH (TYPE_BITS),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (r_blk),
        .i_raddr (ram_raddr),
        .o_rdata (rd_id)
    );

    // grid edge test for the neighbour being checked
    always_comb begin
        unique case (r_dir)
            DIR_UP:   bnd = (32'(r_y) + 32'd1 == SIZE_Y);
            DIR_DOWN: bnd = (r_y == '0);
            DIR_XP:   bnd = (32'(r_x) + 32'd1 == SIZE_X);
            DIR_XN:   bnd = (r_x == '0);
            DIR_ZP:   bnd = (32'(r_z) + 32'd1 == SIZE_Z);
            DIR_ZN:   bnd = (r_z == '0);
            default:  bnd = 1'b0;
        endcase
    end

    always_comb begin
        if (r_liquid) begin
            face_bit = (r_dir == DIR_UP) && (bnd || (rd_id == empty_t));
        end else begin
            face_bit = bnd || (rd_id == empty_t) || (rd_id == liquid_t);
        end
    end

    // lowest pending face goes out first
    always_comb begin
        found    = 1'b0;
        pick_dir = '0;
        pick_hot = '0;
        for (int i = 0; i < NUM_DIRS; i++) begin
            if (!found && r_face[i]) begin
                found       = 1'b1;
                pick_dir    = DIR_W'(i);
                pick_hot[i] = 1'b1;
            end
        end
        rest = r_face & ~pick_hot;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_blk       = r_blk;
        n_want      = r_want;
        n_addr      = r_addr;
        n_dir       = r_dir;
        n_liquid    = r_liquid;
        n_face      = r_face;
        n_out_valid = 1'b0;
        n_out_dir   = r_out_dir;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (start && in_range) begin
                    n_op    = i_op;
                    n_x     = i_pos_x;
                    n_y     = i_pos_y;
                    n_z     = i_pos_z;
                    n_blk   = TYPE_BITS'(i_block_id);
                    n_want  = TYPE_BITS'(i_wanted_type);
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_addr  = AW'(r_z) * AW'(SIZE_Y) + AW'(r_y);
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_addr  = r_addr * AW'(SIZE_X) + AW'(r_x);
                n_state = (r_op == OP_MESH) ? S_SELF_RD : S_WRITE;
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            S_SELF_RD: begin
                n_state = S_SELF_CHK;
            end
            S_SELF_CHK: begin
                n_face   = '0;
                n_dir    = DIR_UP;
                n_liquid = (rd_id == liquid_t);
                n_state  = (rd_id == r_want) ? S_NEIGH : S_IDLE;
            end
            S_NEIGH: begin
                n_face[r_dir] = face_bit;
                n_dir         = r_dir + DIR_W'(1);
                if (r_dir == DIR_ZN) begin
                    n_state = (n_face == '0) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT: begin
                n_out_valid = found;
                n_out_dir   = pick_dir;
                n_out_last  = (rest == '0);
                n_face      = rest;
                if (rest == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_empty_cfg  <= EMPTY_ID_RST;
            r_liquid_cfg <= LIQUID_ID_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_EMPTY_ID) begin
                    r_empty_cfg <= i_cfg_data;
                end else if (i_cfg_index == CFG_LIQUID_ID) begin
                    r_liquid_cfg <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_blk      <= n_blk;
        r_want     <= n_want;
        r_addr     <= n_addr;
        r_dir      <= n_dir;
        r_liquid   <= n_liquid;
        r_face     <= n_face;
        r_out_dir  <= n_out_dir;
        r_out_last <= n_out_last;
    end

    assign o_face_valid = r_out_valid;
    assign o_face_x     = r_x;
    assign o_face_y     = r_y;
    assign o_face_z     = r_z;
    assign o_face_dir   = r_out_dir;
    assign o_liquid_top = r_liquid;
    assign o_last       = r_out_last;

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Regression for voxel_face_culling_mesher. A directed table builds small
// cell neighborhoods at the grid corners and meshes them, with typed face
// masks where the answer is obvious. Random neighborhoods, noise writes and
// noise meshes then run under several empty/liquid id settings. Every face
// record is compared against a local grid model in order.
// ---------------------------------------------------------------------------
module testbench;
    import vfcm_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int PHASE_ITEMS = 36;
    localparam int NUM_PHASES  = 5;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [DIR_W-1:0]   dir;
        logic               liq;
        logic               last;
    } t_face_rec;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [ID_W-1:0]    blk;
        logic [ID_W-1:0]    want;
        logic               typed;
        logic [NUM_DIRS-1:0] mask;
        logic               liq;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_op = OP_WRITE;
    logic [COORD_W-1:0]    i_pos_x = '0;
    logic [COORD_W-1:0]    i_pos_y = '0;
    logic [COORD_W-1:0]    i_pos_z = '0;
    logic [ID_W-1:0]       i_block_id = '0;
    logic [ID_W-1:0]       i_wanted_type = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_EMPTY_ID;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_face_valid;
    logic [COORD_W-1:0]    o_face_x;
    logic [COORD_W-1:0]    o_face_y;
    logic [COORD_W-1:0]    o_face_z;
    logic [DIR_W-1:0]      o_face_dir;
    logic                  o_liquid_top;
    logic                  o_last;

    voxel_face_culling_mesher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_block_id    (i_block_id),
        .i_wanted_type (i_wanted_type),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_face_valid  (o_face_valid),
        .o_face_x      (o_face_x),
        .o_face_y      (o_face_y),
        .o_face_z      (o_face_z),
        .o_face_dir    (o_face_dir),
        .o_liquid_top  (o_liquid_top),
        .o_last        (o_last)
    );

    always #10 i_clk = ~i_clk;

    logic [ID_W-1:0]    grid_ids [int];
    logic [ID_W-1:0]    empty_reg = EMPTY_ID_RST;
    logic [ID_W-1:0]    liquid_reg = LIQUID_ID_RST;
    t_face_rec          pending_faces [$];
    logic [3*COORD_W-1:0] meshable_cells [$];
    t_stim_row          directed_rows [0:23];
    bit                 idle_on = 1'b1;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 phase_beats = 0;
    int                 write_beats = 0;
    int                 mesh_beats = 0;
    int                 faces_seen = 0;
    int                 cfg_beats = 0;

    function automatic int cell_idx(input int x, input int y, input int z);
        return (z * SIZE_Y_DEF + y) * SIZE_X_DEF + x;
    endfunction

    function automatic logic [ID_W-1:0] id_at(input int x, input int y, input int z);
        if (grid_ids.exists(cell_idx(x, y, z)))
            return grid_ids[cell_idx(x, y, z)];
        return '0;
    endfunction

    function automatic bit is_open(input logic [ID_W-1:0] id);
        return id == empty_reg || id == liquid_reg;
    endfunction

    function automatic void push_faces(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                       input logic [COORD_W-1:0] z,
                                       input logic [NUM_DIRS-1:0] mask, input logic liq);
        int last_dir;
        t_face_rec rec;
        last_dir = -1;
        for (int d = 0; d < NUM_DIRS; d++)
            if (mask[d])
                last_dir = d;
        for (int d = 0; d < NUM_DIRS; d++) begin
            if (mask[d]) begin
                rec.x    = x;
                rec.y    = y;
                rec.z    = z;
                rec.dir  = DIR_W'(d);
                rec.liq  = liq;
                rec.last = (d == last_dir);
                pending_faces.insert(pending_faces.size(), rec);
            end
        end
    endfunction

    // exposed faces of one cell under the current id settings
    function automatic void predict_mesh(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y,
                                         input logic [COORD_W-1:0] z,
                                         input logic [ID_W-1:0] want);
        logic [ID_W-1:0]     self_id;
        logic [NUM_DIRS-1:0] mask;
        logic                liq;
        int                  xi, yi, zi;
        xi = int'(x);
        yi = int'(y);
        zi = int'(z);
        self_id = id_at(xi, yi, zi);
        mask = '0;
        liq = 1'b0;
        if (self_id != want)
            return;
        if (self_id == liquid_reg) begin
            liq = 1'b1;
            mask[DIR_UP] = (yi == SIZE_Y_DEF - 1) || id_at(xi, yi + 1, zi) == empty_reg;
        end else begin
            mask[DIR_UP]   = (yi == SIZE_Y_DEF - 1) || is_open(id_at(xi, yi + 1, zi));
            mask[DIR_DOWN] = (yi == 0) || is_open(id_at(xi, yi - 1, zi));
            mask[DIR_XP]   = (xi == SIZE_X_DEF - 1) || is_open(id_at(xi + 1, yi, zi));
            mask[DIR_XN]   = (xi == 0) || is_open(id_at(xi - 1, yi, zi));
            mask[DIR_ZP]   = (zi == SIZE_Z_DEF - 1) || is_open(id_at(xi, yi, zi + 1));
            mask[DIR_ZN]   = (zi == 0) || is_open(id_at(xi, yi, zi - 1));
        end
        push_faces(x, y, z, mask, liq);
    endfunction

    // one command beat; called and returns right after a rising edge
    task automatic issue_cmd(input logic op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                             input logic [ID_W-1:0] blk, input logic [ID_W-1:0] want,
                             input logic typed, input logic [NUM_DIRS-1:0] mask,
                             input logic liq);
        int gap;
        if (idle_on && $urandom_range(0, 99) < 7) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pos_z       <= z;
        i_block_id    <= blk;
        i_wanted_type <= want;
        do @(posedge i_clk); while (busy);
        phase_beats++;
        if (op == OP_WRITE) begin
            grid_ids[cell_idx(int'(x), int'(y), int'(z))] = blk;
            write_beats++;
        end else begin
            mesh_beats++;
            if (typed)
                push_faces(x, y, z, mask, liq);
            else
                predict_mesh(x, y, z, want);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_faces.size() != 0)
            @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_EMPTY_ID)
            empty_reg = data;
        else if (idx == CFG_LIQUID_ID)
            liquid_reg = data;
        cfg_beats++;
        @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] edge_vals [4];
        edge_vals = '{6'd0, 6'd1, 6'd62, 6'd63};
        if ($urandom_range(0, 99) < 40)
            return edge_vals[$urandom_range(0, 3)];
        return COORD_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] center);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return empty_reg;
        if (r < 45)
            return liquid_reg;
        if (r < 70)
            return center;
        return ID_W'($urandom);
    endfunction

    // write a cell and its in-grid neighbors that hold no id yet (others by chance), then mesh the cell
    task automatic random_neighborhood();
        int dx [7];
        int dy [7];
        int dz [7];
        int r, nx, ny, nz;
        logic [COORD_W-1:0] cx, cy, cz;
        logic [ID_W-1:0] ctype, want;
        dx = '{0, 0, 0, 1, -1, 0, 0};
        dy = '{0, 1, -1, 0, 0, 0, 0};
        dz = '{0, 0, 0, 0, 0, 1, -1};
        cx = pick_coord();
        cy = pick_coord();
        cz = pick_coord();
        r = $urandom_range(0, 99);
        if (r < 15)
            ctype = liquid_reg;
        else if (r < 25)
            ctype = empty_reg;
        else
            ctype = ID_W'($urandom);
        for (int k = 6; k >= 0; k--) begin
            nx = int'(cx) + dx[k];
            ny = int'(cy) + dy[k];
            nz = int'(cz) + dz[k];
            if (nx < 0 || ny < 0 || nz < 0 || nx >= SIZE_X_DEF || ny >= SIZE_Y_DEF ||
                nz >= SIZE_Z_DEF)
                continue;
            if (k == 0)
                issue_cmd(OP_WRITE, cx, cy, cz, ctype, ID_W'($urandom), 1'b0, '0, 1'b0);
            else if (!grid_ids.exists(cell_idx(nx, ny, nz)) || $urandom_range(0, 99) < 30)
                issue_cmd(OP_WRITE, COORD_W'(nx), COORD_W'(ny), COORD_W'(nz), pick_id(ctype),
                          ID_W'($urandom), 1'b0, '0, 1'b0);
        end
        want = ($urandom_range(0, 99) < 85) ? ctype : ID_W'($urandom);
        issue_cmd(OP_MESH, cx, cy, cz, ID_W'($urandom), want, 1'b0, '0, 1'b0);
        meshable_cells.insert(meshable_cells.size(), {cx, cy, cz});
    endtask

    task automatic random_phase();
        int r;
        logic [3*COORD_W-1:0] pick_xyz;
        phase_beats = 0;
        while (phase_beats < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 75 || meshable_cells.size() == 0) begin
                random_neighborhood();
            end else if (r < 90) begin
                pick_xyz = meshable_cells[$urandom_range(0, meshable_cells.size() - 1)];
                issue_cmd(OP_MESH, pick_xyz[17:12], pick_xyz[11:6], pick_xyz[5:0],
                          ID_W'($urandom), ID_W'($urandom), 1'b0, '0, 1'b0);
            end else begin
                issue_cmd(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                          ID_W'($urandom), ID_W'($urandom), 1'b0, '0, 1'b0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("voxel_face_culling_mesher regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_face_rec want_rec;
        if (i_rst_n && o_face_valid) begin
            faces_seen++;
            if (pending_faces.size() == 0) begin
                $error("unexpected face beat x=%0d y=%0d z=%0d dir=%0d",
                       o_face_x, o_face_y, o_face_z, o_face_dir);
                fail_count++;
            end else begin
                want_rec = pending_faces.pop_front();
                if (o_face_x !== want_rec.x) begin
                    $error("face_x: expected %0d, actual %0d", want_rec.x, o_face_x);
                    fail_count++;
                end
                if (o_face_y !== want_rec.y) begin
                    $error("face_y: expected %0d, actual %0d", want_rec.y, o_face_y);
                    fail_count++;
                end
                if (o_face_z !== want_rec.z) begin
                    $error("face_z: expected %0d, actual %0d", want_rec.z, o_face_z);
                    fail_count++;
                end
                if (o_face_dir !== want_rec.dir) begin
                    $error("face_dir: expected %0d, actual %0d", want_rec.dir, o_face_dir);
                    fail_count++;
                end
                if (o_liquid_top !== want_rec.liq) begin
                    $error("liquid_top: expected %0d, actual %0d", want_rec.liq, o_liquid_top);
                    fail_count++;
                end
                if (o_last !== want_rec.last) begin
                    $error("last: expected %0d, actual %0d", want_rec.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] empty_set [NUM_PHASES];
        logic [CFG_DATA_W-1:0] liquid_set [NUM_PHASES];
        t_stim_row row;
        empty_set  = '{EMPTY_ID_RST, 4'd15, 4'd6, 4'd0, 4'd9};
        liquid_set = '{LIQUID_ID_RST, 4'd0, 4'd6, 4'd15, 4'd3};
        // op, x, y, z, block, wanted, typed, face mask (bit per dir), liquid
        directed_rows = '{
            '{OP_WRITE, 6'd1,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd0,  6'd1,  6'd0,  4'd0,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd0,  6'd0,  6'd1,  4'd0,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd0,  6'd0,  6'd0,  4'd5,  4'd0,  1'b0, 6'b000000, 1'b0},
            // solid corner cell, open on every side
            '{OP_MESH,  6'd0,  6'd0,  6'd0,  4'd0,  4'd5,  1'b1, 6'b111111, 1'b0},
            // type mismatch
            '{OP_MESH,  6'd0,  6'd0,  6'd0,  4'd0,  4'd4,  1'b1, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd62, 6'd63, 6'd63, 4'd1,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd63, 6'd62, 6'd63, 4'd15, 4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd63, 6'd63, 6'd62, 4'd15, 4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd63, 6'd63, 6'd63, 4'd15, 4'd0,  1'b0, 6'b000000, 1'b0},
            // far corner: grid edges and liquid neighbor open, solid neighbors hide
            '{OP_MESH,  6'd63, 6'd63, 6'd63, 4'd0,  4'd15, 1'b1, 6'b011101, 1'b0},
            '{OP_WRITE, 6'd1,  6'd63, 6'd0,  4'd9,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd0,  6'd62, 6'd0,  4'd0,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd0,  6'd63, 6'd1,  4'd2,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd0,  6'd63, 6'd0,  4'd1,  4'd0,  1'b0, 6'b000000, 1'b0},
            // liquid at the top of the grid
            '{OP_MESH,  6'd0,  6'd63, 6'd0,  4'd0,  4'd1,  1'b1, 6'b000001, 1'b1},
            '{OP_WRITE, 6'd0,  6'd0,  6'd0,  4'd1,  4'd0,  1'b0, 6'b000000, 1'b0},
            // liquid under an empty cell
            '{OP_MESH,  6'd0,  6'd0,  6'd0,  4'd0,  4'd1,  1'b1, 6'b000001, 1'b1},
            '{OP_WRITE, 6'd0,  6'd1,  6'd0,  4'd7,  4'd0,  1'b0, 6'b000000, 1'b0},
            // liquid covered by a solid cell
            '{OP_MESH,  6'd0,  6'd0,  6'd0,  4'd0,  4'd1,  1'b1, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd2,  6'd0,  6'd0,  4'd3,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd1,  6'd1,  6'd0,  4'd0,  4'd0,  1'b0, 6'b000000, 1'b0},
            '{OP_WRITE, 6'd1,  6'd0,  6'd1,  4'd1,  4'd0,  1'b0, 6'b000000, 1'b0},
            // empty cell meshed as its own type
            '{OP_MESH,  6'd1,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'b000000, 1'b0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            issue_cmd(row.op, row.x, row.y, row.z, row.blk, row.want, row.typed, row.mask,
                      row.liq);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                settle();
                write_reg(CFG_EMPTY_ID, empty_set[p]);
                write_reg(CFG_LIQUID_ID, liquid_set[p]);
            end
            // one phase runs back to back with no idle beats
            idle_on = (p != 2);
            random_phase();
        end
        settle();

        $display("covered %0d write beats and %0d mesh beats, %0d face beats checked",
                 write_beats, mesh_beats, faces_seen);
        $display("over %0d id settings incl. empty equal to liquid, %0d config beats",
                 NUM_PHASES, cfg_beats);
        if (fail_count == 0)
            $display("voxel_face_culling_mesher regression: pass");
        else
            $display("voxel_face_culling_mesher regression: fail");
        $finish;
    end

endmodule
